// ----- rtl/rrnt_pkg.sv -----
package rrnt_pkg;

  typedef enum logic [1:0] {
    MODE_START,
    MODE_SAMPLE,
    MODE_DATA,
    MODE_NONE
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_UNKNOWN,
    ST_BAD_PROX,
    ST_FULL
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_UPD,
    S_FDIV,
    S_ADIV,
    S_AWAIT,
    S_YMUL,
    S_TMUL,
    S_PMUL,
    S_PDIV,
    S_EFIN,
    S_WB,
    S_DONE
  } state_t;

  localparam logic [7:0]  PROX_MIN    = 8'd235;
  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
  localparam logic [29:0] LN2_Q30     = 30'd744261118;
  localparam logic [22:0] LOG2_10_Q24 = 23'd2786646;

  // Reciprocals for the Taylor divisions; exact for numerators below 2^31.
  localparam logic [31:0] RECIP_3 = 32'd2863311531;
  localparam logic [31:0] RECIP_5 = 32'd3435973837;
  localparam logic [31:0] RECIP_6 = 32'd2863311531;
  localparam logic [31:0] RECIP_7 = 32'd2454267027;

  function automatic logic [15:0] log_term_q8(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0:  v = -16'sd6661;
      5'd1:  v = -16'sd15313;
      5'd2:  v = -16'sd13772;
      5'd3:  v = -16'sd12870;
      5'd4:  v = -16'sd12231;
      5'd5:  v = -16'sd11734;
      5'd6:  v = -16'sd11329;
      5'd7:  v = -16'sd10986;
      5'd8:  v = -16'sd10689;
      5'd9:  v = -16'sd10427;
      5'd10: v = -16'sd10193;
      5'd11: v = -16'sd9981;
      5'd12: v = -16'sd9788;
      5'd13: v = -16'sd9610;
      5'd14: v = -16'sd9445;
      5'd15: v = -16'sd9292;
      5'd16: v = -16'sd9148;
      5'd17: v = -16'sd9013;
      5'd18: v = -16'sd8886;
      5'd19: v = -16'sd8766;
      5'd20: v = -16'sd8652;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/rrnt_if.sv -----
interface rrnt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] node_address;
  logic [7:0]  proximity;
  logic [7:0]  rssi;
  logic [15:0] temperature;

  modport source(output valid, mode, node_address, proximity, rssi, temperature,
                 input ready);
  modport sink(input valid, mode, node_address, proximity, rssi, temperature,
               output ready);
endinterface

interface rrnt_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  node_slot;
  logic        calibrated;
  logic [31:0] distance_q16;
  logic [23:0] avg_temperature_q8;

  modport source(output valid, status, node_slot, calibrated, distance_q16,
                 avg_temperature_q8, input ready);
  modport sink(input valid, status, node_slot, calibrated, distance_q16,
               avg_temperature_q8, output ready);
endinterface

// ----- rtl/rrnt_div.sv -----
module rrnt_div #(
  parameter int DW  = 32,
  parameter int DVW = 7
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DW-1:0]  num,
  input  logic [DVW-1:0] den,
  output logic           busy,
  output logic           done,
  output logic [DW-1:0]  quo
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0]  cnt;
  logic [DVW:0]   rem;
  logic [DVW-1:0] den_r;
  logic [DW-1:0]  q;
  logic [DVW:0]   rem_sh;
  logic           ge;

  assign rem_sh = {rem[DVW-1:0], q[DW-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign quo    = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        q     <= num;
        den_r <= den;
      end else if (busy) begin
        rem <= ge ? rem_sh - {1'b0, den_r} : rem_sh;
        q   <= {q[DW-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/rssi_ranging_node_table.sv -----
// Neighbor table with RSSI ranging.
// A request on the request channel carries mode, node address, proximity,
// RSSI and temperature; every request yields exactly one item on the
// result channel. The own temperature must be written through
// cfg_we/cfg_wdata only while the block is idle; the block itself does not
// enforce this. The node table sits in one single-port memory that is
// searched linearly, each slot read followed by a compare. An unused mode
// goes straight to the result. A data request on a known node computes the
// average temperature on a restoring divider whose width is DW bits, with
// DW = max(32, 26 + log2(NODE_SLOTS)). The sample that completes a
// calibration computes the factor and then the exponential for the distance,
// and a data request on a calibrated node the exponential after the average.
// One request is worked on at a time. The finished result is held in an
// output register, and the next request is accepted in the cycle after it is
// loaded, also while it waits; a stalled receiver holds the block only when
// a second result is ready to be loaded.
// Reset clears the node count, the temperature sum, the average and the
// own temperature; memory entries are written when a node is added.
module rssi_ranging_node_table
  import rrnt_pkg::*;
#(
  parameter int NODE_SLOTS  = 16,
  parameter int CAL_SAMPLES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  rrnt_req_if.sink    request,
  rrnt_res_if.source  result
);

  localparam int SLOT_W = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NODE_SLOTS + 1);
  localparam int STEP_W = $clog2(CAL_SAMPLES + 1);
  localparam int TS_W   = 17 + $clog2(NODE_SLOTS);
  localparam int AN_W   = TS_W + 9;
  localparam int DW     = (AN_W > 32) ? AN_W : 32;
  localparam int DVW    = (CNT_W + 1 > 7) ? CNT_W + 1 : 7;
  localparam int CS_SH  = 24 + $clog2(CAL_SAMPLES);
  localparam logic [24:0] CS_RECIP =
    25'(((64'd1 << CS_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

  typedef struct packed {
    logic [15:0]       addr;
    logic [STEP_W-1:0] step;
    logic              done;
    logic [23:0]       sum;
    logic [17:0]       factor;
    logic [7:0]        rssi;
    logic [15:0]       temp;
    logic [31:0]       distance;
  } entry_t;

  state_t state, state_next;

  entry_t mem [NODE_SLOTS];
  entry_t rd_data, ent, base, upd_ent;

  mode_t       r_mode;
  logic [15:0] r_addr;
  logic [7:0]  r_prox;
  logic [7:0]  r_rssi;
  logic [15:0] r_temp;

  logic [CNT_W-1:0]  idx, nc;
  logic [SLOT_W-1:0] slot;
  logic              found;
  status_t           status;

  logic signed [TS_W-1:0] temp_sum;
  logic [23:0]            avg_temp;
  logic [15:0]            self_temp;

  logic               div_neg;
  logic signed [41:0] y;
  logic signed [9:0]  ip;
  logic [29:0]        t;
  logic [31:0]        acc, p;
  logic [2:0]         n;

  logic           out_valid;
  status_t        o_status;
  logic [3:0]     o_slot;
  logic           o_cal;
  logic [31:0]    o_dist;
  logic [23:0]    o_avg;

  logic           div_start, div_busy, div_done, neg_sel;
  logic [DW-1:0]  div_num, div_quo;
  logic [DVW-1:0] div_den;

  logic              prox_ok, match;
  logic [15:0]       lg;
  logic [23:0]       sum_n, mag24;
  logic [STEP_W-1:0] step_n;
  logic [48:0]       prod_f;
  logic [17:0]       fq;
  logic signed [TS_W:0]   tsum_self;
  logic signed [AN_W-1:0] avg_num, avg_mag;
  logic signed [18:0]     e_val;
  logic signed [41:0]     prod_y;
  logic [61:0]            prod_t, prod_p;
  logic [31:0]            recip, p_quo;
  logic [63:0]            prod_q;
  logic signed [9:0]      shv;
  logic [31:0]            dist_calc;

  assign request.ready             = (state == S_IDLE);
  assign result.valid              = out_valid;
  assign result.status             = o_status;
  assign result.node_slot          = o_slot;
  assign result.calibrated         = o_cal;
  assign result.distance_q16       = o_dist;
  assign result.avg_temperature_q8 = o_avg;

  assign match   = (rd_data.addr == r_addr);
  assign prox_ok = (r_prox >= PROX_MIN);
  assign lg      = log_term_q8(~r_prox[4:0]);

  always_comb begin
    base = ent;
    if (r_mode == MODE_START) begin
      base.step = '0;
      base.done = 1'b0;
      base.sum  = '0;
    end
  end

  assign sum_n  = base.sum + {{8{r_rssi[7]}}, r_rssi, 8'h00} + {{8{lg[15]}}, lg};
  assign step_n = base.step + 1'b1;
  assign mag24  = ent.sum[23] ? 24'(-ent.sum) : ent.sum;
  assign prod_f = {25'b0, mag24} * {24'b0, CS_RECIP};
  assign fq     = 18'(prod_f >> CS_SH);

  always_comb begin
    upd_ent = base;
    if (r_mode == MODE_DATA) begin
      upd_ent.rssi = r_rssi;
      upd_ent.temp = r_temp;
    end else if (prox_ok && base.step < STEP_W'(CAL_SAMPLES)) begin
      upd_ent.sum  = sum_n;
      upd_ent.step = step_n;
      upd_ent.done = (step_n == STEP_W'(CAL_SAMPLES));
    end
  end

  assign tsum_self = {temp_sum[TS_W-1], temp_sum}
                   + {{(TS_W + 1 - 16){self_temp[15]}}, self_temp};
  assign avg_num   = {tsum_self, 8'h00};
  assign avg_mag   = avg_num[AN_W-1] ? -avg_num : avg_num;

  assign e_val  = {ent.factor[17], ent.factor} - {{3{ent.rssi[7]}}, ent.rssi, 8'h00};
  assign prod_y = $signed({{23{e_val[18]}}, e_val}) * $signed({19'b0, LOG2_10_Q24});
  assign prod_t = {30'b0, y[31:0]} * {32'b0, LN2_Q30};
  assign prod_p = {30'b0, acc} * {32'b0, t};
  assign prod_q = {32'b0, p} * {32'b0, recip};
  assign shv    = 10'sd14 - ip;

  always_comb begin
    case (n)
      3'd3:    recip = RECIP_3;
      3'd5:    recip = RECIP_5;
      3'd6:    recip = RECIP_6;
      3'd7:    recip = RECIP_7;
      default: recip = '0;
    endcase
  end

  always_comb begin
    case (n)
      3'd2:             p_quo = {1'b0, p[31:1]};
      3'd3:             p_quo = {1'b0, prod_q[63:33]};
      3'd4:             p_quo = {2'b0, p[31:2]};
      3'd5, 3'd6, 3'd7: p_quo = {2'b0, prod_q[63:34]};
      default:          p_quo = p;
    endcase
  end

  always_comb begin
    if (ip > 10'sd15) begin
      dist_calc = 32'hFFFF_FFFF;
    end else if (ip == 10'sd15) begin
      dist_calc = {acc[30:0], 1'b0};
    end else if (ip < -10'sd17) begin
      dist_calc = '0;
    end else begin
      dist_calc = acc >> shv[4:0];
    end
  end

  always_comb begin
    div_start = 1'b0;
    neg_sel   = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      S_ADIV: begin
        div_start = 1'b1;
        neg_sel   = avg_num[AN_W-1];
        div_num   = DW'(unsigned'(avg_mag));
        div_den   = DVW'(nc) + 1'b1;
      end
      default: begin
      end
    endcase
  end

  rrnt_div #(
    .DW  (DW),
    .DVW (DVW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (state == S_RD && idx != nc) begin
      rd_data <= mem[idx[SLOT_W-1:0]];
    end
    if (state == S_WB) begin
      mem[slot] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (request.valid) begin
          state_next = (mode_t'(request.mode) == MODE_NONE) ? S_DONE : S_RD;
        end
      end
      S_RD: begin
        if (idx == nc) begin
          state_next = (r_mode == MODE_START && nc != CNT_W'(NODE_SLOTS)) ? S_UPD : S_DONE;
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: state_next = match ? S_UPD : S_RD;
      S_UPD: begin
        if (r_mode == MODE_DATA) begin
          state_next = S_ADIV;
        end else if (prox_ok && base.step < STEP_W'(CAL_SAMPLES)
                     && step_n == STEP_W'(CAL_SAMPLES)) begin
          state_next = S_FDIV;
        end else begin
          state_next = S_WB;
        end
      end
      S_FDIV:  state_next = S_YMUL;
      S_ADIV:  state_next = S_AWAIT;
      S_AWAIT: if (div_done) state_next = ent.done ? S_YMUL : S_WB;
      S_YMUL:  state_next = S_TMUL;
      S_TMUL:  state_next = S_PMUL;
      S_PMUL:  state_next = S_PDIV;
      S_PDIV:  state_next = (n == 3'd1) ? S_EFIN : S_PMUL;
      S_EFIN:  state_next = S_WB;
      S_WB:    state_next = S_DONE;
      S_DONE:  if (!out_valid || result.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nc        <= '0;
      temp_sum  <= '0;
      avg_temp  <= '0;
      self_temp <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        self_temp <= cfg_wdata;
      end
      if (state == S_DONE && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (div_start) begin
        div_neg <= neg_sel;
      end
      case (state)
        S_IDLE: begin
          if (request.valid) begin
            r_mode <= mode_t'(request.mode);
            r_addr <= request.node_address;
            r_prox <= request.proximity;
            r_rssi <= request.rssi;
            r_temp <= request.temperature;
            idx    <= '0;
            found  <= 1'b0;
            status <= ST_OK;
          end
        end
        S_RD: begin
          if (idx == nc) begin
            if (r_mode == MODE_START && nc != CNT_W'(NODE_SLOTS)) begin
              slot  <= nc[SLOT_W-1:0];
              ent   <= '{addr: r_addr, default: '0};
              found <= 1'b1;
              nc    <= nc + 1'b1;
            end else if (r_mode == MODE_START) begin
              status <= ST_FULL;
            end else begin
              status <= ST_UNKNOWN;
            end
          end
        end
        S_CMP: begin
          if (match) begin
            ent   <= rd_data;
            slot  <= idx[SLOT_W-1:0];
            found <= 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_UPD: begin
          ent <= upd_ent;
          if (r_mode == MODE_DATA) begin
            temp_sum <= temp_sum + TS_W'($signed(r_temp)) - TS_W'($signed(ent.temp));
          end else if (!prox_ok) begin
            status <= ST_BAD_PROX;
          end
        end
        S_FDIV: ent.factor <= ent.sum[23] ? -fq : fq;
        S_AWAIT: begin
          if (div_done) begin
            avg_temp <= div_neg ? -div_quo[23:0] : div_quo[23:0];
          end
        end
        S_YMUL: y <= prod_y;
        S_TMUL: begin
          t   <= prod_t[61:32];
          ip  <= y[41:32];
          acc <= ONE_Q30;
          n   <= 3'd7;
        end
        S_PMUL: p <= prod_p[61:30];
        S_PDIV: begin
          acc <= ONE_Q30 + p_quo;
          n   <= n - 1'b1;
        end
        S_EFIN: ent.distance <= dist_calc;
        S_DONE: begin
          if (!out_valid || result.ready) begin
            o_status  <= status;
            o_slot    <= found ? 4'(slot) : 4'd0;
            o_cal     <= found & ent.done;
            o_dist    <= found ? ent.distance : 32'd0;
            o_avg     <= avg_temp;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    nc <= CNT_W'(NODE_SLOTS))
    else $error("node count above table size");

  a_wb_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB) |-> (CNT_W'(slot) < nc))
    else $error("write-back to a slot that is not in use");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready) |=> !request.ready)
    else $error("second request accepted while one is in work");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == ST_FULL) |-> (nc == CNT_W'(NODE_SLOTS)))
    else $error("table full reported with free slots");
`endif

endmodule

// ----- verif/tb_rssi_ranging_node_table.sv -----
`timescale 1ns / 100ps

module tb_rssi_ranging_node_table;
  import rrnt_pkg::*;

  localparam int SLOTS = 16;
  localparam int SAMPLES = 8;

  typedef struct {
    mode_t              mode;
    bit [15:0]          addr;
    bit [7:0]           prox;
    bit signed [7:0]    rssi;
    bit signed [15:0]   temp;
  } ranging_req_t;

  typedef struct {
    status_t   status;
    bit [3:0]  slot;
    bit        cal;
    bit [31:0] distance;
    bit [23:0] avg;
  } ranging_res_t;

  class ranging_scoreboard;
    ranging_res_t       pending_q[$];
    int                 errors;
    bit signed [15:0]   self_temp;
    bit [4:0]           count;
    bit [15:0]          addr_tab[SLOTS];
    bit [3:0]           steps[SLOTS];
    bit                 done[SLOTS];
    bit signed [23:0]   sum_q8[SLOTS];
    bit signed [17:0]   factor_q8[SLOTS];
    bit signed [7:0]    rssi_tab[SLOTS];
    bit signed [15:0]   temp_tab[SLOTS];
    bit [31:0]          dist_tab[SLOTS];
    bit signed [20:0]   temp_sum;
    bit signed [23:0]   avg_reg;
    int                 log_tab[21];

    function new();
      log_tab = '{-6661, -15313, -13772, -12870, -12231, -11734, -11329,
                  -10986, -10689, -10427, -10193, -9981, -9788, -9610,
                  -9445, -9292, -9148, -9013, -8886, -8766, -8652};
      errors = 0;
      self_temp = 0;
      count = 0;
      temp_sum = 0;
      avg_reg = 0;
      for (int i = 0; i < SLOTS; i++) begin
        addr_tab[i] = 0; steps[i] = 0; done[i] = 0; sum_q8[i] = 0;
        factor_q8[i] = 0; rssi_tab[i] = 0; temp_tab[i] = 0; dist_tab[i] = 0;
      end
    endfunction

    function int lookup(bit [15:0] a);
      for (int i = 0; i < count; i++)
        if (addr_tab[i] == a) return i;
      return -1;
    endfunction

    function bit [31:0] range_q16(int e);
      longint y, ip, sh;
      longint unsigned frac, t, acc;
      y = longint'(e) * 64'sd2786646;
      frac = y & 64'hFFFF_FFFF;
      ip = (y - longint'(frac)) >>> 32;
      t = (frac * 64'd744261118) >> 32;
      acc = 64'd1 << 30;
      for (int n = 7; n >= 1; n--)
        acc = (64'd1 << 30) + ((acc * t) >> 30) / n;
      if (ip >= 16) return 32'hFFFF_FFFF;
      sh = 14 - ip;
      if (sh < 0) return 32'(acc << 1);
      if (sh >= 32) return 0;
      return 32'(acc >> sh);
    endfunction

    function void refresh_distance(int s);
      if (done[s])
        dist_tab[s] = range_q16(int'(factor_q8[s]) - int'(rssi_tab[s]) * 256);
    endfunction

    function status_t take_sample(int s, bit [7:0] p, bit signed [7:0] r);
      if (p < 8'd235) return ST_BAD_PROX;
      if (steps[s] < SAMPLES) begin
        sum_q8[s] = sum_q8[s] + int'(r) * 256 + log_tab[255 - p];
        steps[s] = steps[s] + 1;
        if (steps[s] >= SAMPLES) begin
          factor_q8[s] = int'(sum_q8[s]) / SAMPLES;
          done[s] = 1;
          refresh_distance(s);
        end else begin
          done[s] = 0;
        end
      end
      return ST_OK;
    endfunction

    function void note_request(ranging_req_t q);
      ranging_res_t r;
      int s;
      longint num;
      s = -1;
      r.status = ST_OK;
      case (q.mode)
        MODE_START: begin
          s = lookup(q.addr);
          if (s < 0) begin
            if (count >= SLOTS) begin
              r.status = ST_FULL;
            end else begin
              s = count;
              addr_tab[s] = q.addr; rssi_tab[s] = 0; temp_tab[s] = 0;
              dist_tab[s] = 0; factor_q8[s] = 0;
              count = count + 1;
            end
          end
          if (s >= 0) begin
            done[s] = 0; steps[s] = 0; sum_q8[s] = 0;
            r.status = take_sample(s, q.prox, q.rssi);
          end
        end
        MODE_SAMPLE: begin
          s = lookup(q.addr);
          if (s < 0) r.status = ST_UNKNOWN;
          else r.status = take_sample(s, q.prox, q.rssi);
        end
        MODE_DATA: begin
          s = lookup(q.addr);
          if (s < 0) begin
            r.status = ST_UNKNOWN;
          end else begin
            rssi_tab[s] = q.rssi;
            temp_sum = temp_sum + q.temp - temp_tab[s];
            temp_tab[s] = q.temp;
            num = (longint'(temp_sum) + longint'(self_temp)) * 256;
            avg_reg = 24'(num / longint'(count + 1));
            refresh_distance(s);
          end
        end
        default: ;
      endcase
      if (s >= 0) begin
        r.slot = s[3:0]; r.cal = done[s]; r.distance = dist_tab[s];
      end else begin
        r.slot = 0; r.cal = 0; r.distance = 0;
      end
      r.avg = avg_reg;
      pending_q.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      $display("MISMATCH %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(ranging_res_t got);
      ranging_res_t want;
      if (pending_q.size() == 0) begin
        report("unexpected result", got.status, 0);
      end else begin
        want = pending_q.pop_front();
        if (got.status != want.status) report("status", got.status, want.status);
        if (got.slot != want.slot) report("node_slot", got.slot, want.slot);
        if (got.cal != want.cal) report("calibrated", got.cal, want.cal);
        if (got.distance != want.distance)
          report("distance_q16", got.distance, want.distance);
        if (got.avg != want.avg) report("avg_temperature_q8", got.avg, want.avg);
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  rrnt_req_if  req_bus ();
  rrnt_res_if  res_bus ();

  rssi_ranging_node_table dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .request   (req_bus),
    .result    (res_bus)
  );

  ranging_scoreboard sb = new();
  int        hold_left = 0;
  int        burst_left = 0;
  bit [15:0] addr_pool[20];

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_wdata = 0;
    req_bus.valid = 0;
    req_bus.mode = MODE_START;
    req_bus.node_address = 0;
    req_bus.proximity = 0;
    req_bus.rssi = 0;
    req_bus.temperature = 0;
    res_bus.ready = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
  end

  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int phase_left, stall_kind;
    ranging_res_t got;
    phase_left = 0;
    stall_kind = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_bus.valid && res_bus.ready) begin
        got.status = status_t'(res_bus.status);
        got.slot = res_bus.node_slot;
        got.cal = res_bus.calibrated;
        got.distance = res_bus.distance_q16;
        got.avg = res_bus.avg_temperature_q8;
        sb.check_result(got);
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 200);
        stall_kind = $urandom_range(0, 2);
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 0;
      end else if (stall_kind == 0) begin
        res_bus.ready <= 1;
      end else if (stall_kind == 1) begin
        res_bus.ready <= ($urandom_range(0, 3) != 0);
      end else begin
        res_bus.ready <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  task send_request(ranging_req_t q);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        req_bus.valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 25);
    end
    burst_left--;
    req_bus.valid <= 1;
    req_bus.mode <= q.mode;
    req_bus.node_address <= q.addr;
    req_bus.proximity <= q.prox;
    req_bus.rssi <= q.rssi;
    req_bus.temperature <= q.temp;
    do @(posedge clk); while (!req_bus.ready);
    sb.note_request(q);
  endtask

  task drain_results();
    req_bus.valid <= 0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_self_temp(bit [15:0] v);
    drain_results();
    cfg_wdata <= v;
    cfg_we <= 1;
    @(posedge clk);
    cfg_we <= 0;
    sb.self_temp = v;
  endtask

  function ranging_req_t make_req(mode_t m, bit [15:0] a, bit [7:0] p, bit [7:0] r,
                                  bit [15:0] t);
    ranging_req_t q;
    q.mode = m; q.addr = a; q.prox = p; q.rssi = r; q.temp = t;
    return q;
  endfunction

  function bit [7:0] pick_prox();
    if ($urandom_range(0, 9) < 8) return 8'($urandom_range(235, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  task random_chunk(int n);
    int sent;
    bit [15:0] a;
    sent = 0;
    while (sent < n) begin
      a = addr_pool[$urandom_range(0, 19)];
      if ($urandom_range(0, 3) != 0) begin
        send_request(make_req(MODE_START, a, pick_prox(), 8'($urandom), 16'($urandom)));
        for (int i = 0; i < SAMPLES - 1; i++)
          send_request(make_req(MODE_SAMPLE, a, pick_prox(), 8'($urandom),
                                16'($urandom)));
        repeat ($urandom_range(1, 3))
          send_request(make_req(MODE_DATA, a, 8'($urandom), 8'($urandom),
                                16'($urandom)));
        sent += SAMPLES + 2;
      end else begin
        if ($urandom_range(0, 1) == 0) a = 16'($urandom);
        send_request(make_req(mode_t'($urandom_range(0, 3)), a, 8'($urandom),
                              8'($urandom), 16'($urandom)));
        sent++;
      end
    end
  endtask

  initial begin
    bit [15:0] a, b;
    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'hFFFF;
    for (int i = 2; i < 20; i++) addr_pool[i] = 16'($urandom);
    a = addr_pool[0];
    b = addr_pool[1];
    @(negedge rst);
    @(posedge clk);
    write_self_temp(16'h8000);

    send_request(make_req(MODE_NONE, 16'h1234, 8'd255, 8'h7F, 16'h7FFF));
    send_request(make_req(MODE_SAMPLE, a, 8'd250, 8'h00, 16'h0000));
    send_request(make_req(MODE_DATA, a, 8'd250, 8'h00, 16'h0100));
    send_request(make_req(MODE_START, a, 8'd234, 8'h10, 16'h0000));
    send_request(make_req(MODE_START, a, 8'd255, 8'h80, 16'h0000));
    for (int i = 0; i < SAMPLES - 1; i++)
      send_request(make_req(MODE_SAMPLE, a, 8'(235 + i * 3), 8'h7F, 16'h0000));
    send_request(make_req(MODE_SAMPLE, a, 8'd240, 8'h00, 16'h0000));
    send_request(make_req(MODE_DATA, a, 8'd0, 8'h80, 16'h7FFF));
    send_request(make_req(MODE_DATA, a, 8'd0, 8'h7F, 16'h8000));
    send_request(make_req(MODE_START, b, 8'd0, 8'h00, 16'h0000));
    send_request(make_req(MODE_DATA, b, 8'd0, 8'hC0, 16'h1234));
    send_request(make_req(MODE_START, a, 8'd245, 8'hE0, 16'h0000));
    send_request(make_req(MODE_SAMPLE, a, 8'd100, 8'h00, 16'h0000));

    write_self_temp(16'h7FFF);
    random_chunk(120);
    write_self_temp(16'($urandom));
    hold_left = 3000;
    random_chunk(120);
    drain_results();
    write_self_temp(16'h8000);
    random_chunk(120);
    write_self_temp(16'h0000);
    random_chunk(120);

    drain_results();
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
